@@ rtl/core/vmag_pkg.sv @@
`timescale 1ns / 1ps

package vmag_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_ACCESS = 2'd0,
    ST_MASKED = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_UNIT    = 2'd0,
    MODE_INDEXED = 2'd1,
    MODE_STRIDED = 2'd2,
    MODE_WHOLE   = 2'd3
  } mode_e;

  // vlenb register is 17 bits wide, so log2 fits in 5 bits
  localparam int unsigned VBYTES_W = 17;
  localparam int unsigned LG_W     = 5;

  typedef struct packed {
    status_e          status;
    logic             is_store;
    mode_e            mode;
    logic [2:0]       nf_m1;
    logic [1:0]       size_lg;
    logic [1:0]       lmul_sh;
    logic [4:0]       vd;
    logic [LG_W-1:0]  lg;
  } dec_t;

endpackage

@@ rtl/core/vector_mem_element_address_gen_top.sv @@
`timescale 1ns / 1ps
// A request's first result is registered in stages 1-3, the sequencer element and output registers.
// Throughput: the field sequencer sends one result per cycle while out_stall_i is low, so a request
//   holds it for nf results (one for a masked-off or rejected element); back pressure from it stalls input.
// Front end is three register stages: decode, offset product (11x64 stride multiply), address add.
// Reset (async, active low) clears all valid bits; vector_present=1, vector_bytes=16, vtype=0.

module vector_mem_element_address_gen_top import vmag_pkg::*; #(
  parameter int unsigned MAX_VECTOR_BYTES = 256,
  parameter int unsigned MAX_FIELDS       = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [VBYTES_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         instruction_i,
  input  logic [63:0]         base_address_i,
  input  logic [63:0]         stride_value_i,
  input  logic [10:0]         element_number_i,
  input  logic [63:0]         offset_value_i,
  input  logic                mask_bit_i,
  input  logic                vector_enabled_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [63:0]         memory_address_o,
  output logic [4:0]          register_number_o,
  output logic [7:0]          register_offset_o,
  output logic [3:0]          access_bytes_o,
  output logic                is_store_o,
  output logic [2:0]          field_number_o,
  output logic                last_o
);

  localparam logic [1:0] CFG_PRESENT = 2'd0;
  localparam logic [1:0] CFG_BYTES   = 2'd1;
  localparam logic [1:0] CFG_TYPE    = 2'd2;

  localparam int unsigned LG_MAX = $clog2(MAX_VECTOR_BYTES);
  // f * lmul_bytes < 2^(LG_MAX+6), element * size < 2^14
  localparam int unsigned OFF_W  = ((LG_MAX + 6 > 14) ? LG_MAX + 6 : 14) + 1;

  logic                present_q;
  logic [VBYTES_W-1:0] vbytes_q;
  logic [7:0]          vtype_q;

  dec_t                dec;

  logic                s1_v_q, s2_v_q, s3_v_q;
  logic                s1_ready, s2_ready, s3_ready, seq_ready;

  dec_t                s1_dec_q;
  logic [63:0]         s1_base_q;
  logic [63:0]         s1_stride_q;
  logic [10:0]         s1_elem_q;
  logic [63:0]         s1_index_q;

  dec_t                s2_dec_q;
  logic [63:0]         s2_base_q;
  logic [63:0]         s2_addend_q;
  logic [13:0]         s2_elem_sz_q;

  dec_t                s3_dec_q;
  logic [63:0]         s3_addr_q;
  logic [OFF_W-1:0]    s3_off_q;
  logic [OFF_W-1:0]    s3_lmul_q;
  logic [VBYTES_W-1:0] s3_step_q;

  logic [74:0]         stride_prod;
  logic [14:0]         elem_nf;
  logic [17:0]         unit_off;
  logic [13:0]         elem_sz;
  logic [63:0]         addend;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b1;
      vbytes_q  <= VBYTES_W'(16);
      vtype_q   <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESENT: present_q <= cfg_wdata_i[0];
        CFG_BYTES:   vbytes_q  <= cfg_wdata_i;
        CFG_TYPE:    vtype_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  vmag_decode #(
    .MAX_VECTOR_BYTES (MAX_VECTOR_BYTES),
    .MAX_FIELDS       (MAX_FIELDS)
  ) u_decode (
    .instruction_i    (instruction_i),
    .mask_bit_i       (mask_bit_i),
    .vector_enabled_i (vector_enabled_i),
    .vector_present_i (present_q),
    .vector_bytes_i   (vbytes_q),
    .vector_type_i    (vtype_q),
    .dec_o            (dec)
  );

  assign s3_ready   = !s3_v_q || seq_ready;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
    end
  end

  // stage 1: decoded request
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_dec_q    <= dec;
      s1_base_q   <= base_address_i;
      s1_stride_q <= stride_value_i;
      s1_elem_q   <= element_number_i;
      s1_index_q  <= offset_value_i;
    end
  end

  // stage 2: element offset from base
  assign stride_prod = 75'(s1_stride_q) * 75'(s1_elem_q);
  assign elem_nf     = 15'(s1_elem_q) * 15'({1'b0, s1_dec_q.nf_m1} + 4'd1);
  assign unit_off    = 18'(elem_nf) << s1_dec_q.size_lg;
  assign elem_sz     = 14'(s1_elem_q) << s1_dec_q.size_lg;

  always_comb begin
    case (s1_dec_q.mode)
      MODE_INDEXED: addend = s1_index_q;
      MODE_STRIDED: addend = stride_prod[63:0];
      MODE_WHOLE:   addend = 64'(elem_sz);
      MODE_UNIT:    addend = 64'(unit_off);
      default:      addend = 64'(unit_off);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_dec_q     <= s1_dec_q;
      s2_base_q    <= s1_base_q;
      s2_addend_q  <= addend;
      s2_elem_sz_q <= elem_sz;
    end
  end

  // stage 3: first field address, per-field increments
  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      s3_dec_q  <= s2_dec_q;
      s3_addr_q <= s2_base_q + s2_addend_q;
      s3_off_q  <= OFF_W'(s2_elem_sz_q);
      s3_lmul_q <= OFF_W'(1) << (6'(s2_dec_q.lg) + 6'(s2_dec_q.lmul_sh));
      if (s2_dec_q.mode == MODE_WHOLE) begin
        s3_step_q <= VBYTES_W'(1) << s2_dec_q.lg;
      end else begin
        s3_step_q <= VBYTES_W'(1) << s2_dec_q.size_lg;
      end
    end
  end

  vmag_field_seq #(
    .OFF_W (OFF_W)
  ) u_field_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s3_v_q),
    .in_ready_o        (seq_ready),
    .dec_i             (s3_dec_q),
    .addr_i            (s3_addr_q),
    .off_i             (s3_off_q),
    .grp_bytes_i       (s3_lmul_q),
    .step_i            (s3_step_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .memory_address_o  (memory_address_o),
    .register_number_o (register_number_o),
    .register_offset_o (register_offset_o),
    .access_bytes_o    (access_bytes_o),
    .is_store_o        (is_store_o),
    .field_number_o    (field_number_o),
    .last_o            (last_o)
  );

`ifndef NO_ASSERTIONS
  a_skip_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ACCESS) |-> last_o && (access_bytes_o == 4'd0))
    else $error("skip result must be a single last result with no access");

  a_size_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ACCESS) |-> $onehot(access_bytes_o))
    else $error("access size must be 1, 2, 4 or 8 bytes");

  a_field_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (field_number_o <= 3'(MAX_FIELDS - 1)))
    else $error("field number beyond field limit");

  a_s3_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && !seq_ready |=> s3_v_q && $stable(s3_addr_q))
    else $error("stage 3 request lost while sequencer busy");

  a_stall_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q && s2_v_q && s3_v_q)
    else $error("input stalled with a free pipeline stage");
`endif

endmodule

@@ rtl/core/vmag_decode.sv @@
`timescale 1ns / 1ps

module vmag_decode import vmag_pkg::*; #(
  parameter int unsigned MAX_VECTOR_BYTES = 256,
  parameter int unsigned MAX_FIELDS       = 8
) (
  input  logic [31:0]         instruction_i,
  input  logic                mask_bit_i,
  input  logic                vector_enabled_i,
  input  logic                vector_present_i,
  input  logic [VBYTES_W-1:0] vector_bytes_i,
  input  logic [7:0]          vector_type_i,
  output dec_t                dec_o
);

  localparam logic [6:0] OPC_STORE   = 7'h27;
  localparam logic [4:0] LUMOP_UNIT  = 5'h00;
  localparam logic [4:0] LUMOP_WHOLE = 5'h08;
  localparam logic [4:0] LUMOP_FF    = 5'h10;
  localparam logic [1:0] MOP_UNIT    = 2'd0;
  localparam logic [1:0] MOP_STRIDE  = 2'd2;

  logic [2:0]      f3;
  logic [1:0]      mop;
  logic [4:0]      umop;
  logic            store;
  logic            whole;
  logic            ff;
  logic            indexed;
  logic            vb_ok;
  logic            width_bad;
  logic            lumop_bad;
  logic            size_bad;
  logic            nf_bad;
  logic            reject;
  logic [LG_W-1:0] lg;

  assign f3      = instruction_i[14:12];
  assign mop     = instruction_i[27:26];
  assign umop    = instruction_i[24:20];
  assign store   = instruction_i[6:0] == OPC_STORE;
  assign indexed = mop[0];
  assign whole   = (mop == MOP_UNIT) && (umop == LUMOP_WHOLE);
  assign ff      = (umop == LUMOP_FF) && !store;

  // scalar FP widths share the major opcode
  assign width_bad = (f3 != 3'd0) && (f3 < 3'd5);
  assign vb_ok     = (vector_bytes_i != '0)
                   && (vector_bytes_i <= VBYTES_W'(MAX_VECTOR_BYTES))
                   && ((vector_bytes_i & (vector_bytes_i - VBYTES_W'(1))) == '0);
  assign lumop_bad = (mop == MOP_UNIT) && (umop != LUMOP_UNIT) && !whole && !ff;
  // index EEW comes from SEW; codes above 3 exceed 8 bytes
  assign size_bad  = indexed && vector_type_i[5];
  assign nf_bad    = {1'b0, instruction_i[31:29]} > 4'(MAX_FIELDS - 1);

  assign reject = width_bad || instruction_i[28] || !vector_present_i ||
                  !vector_enabled_i || !vb_ok || lumop_bad || size_bad || nf_bad;

  always_comb begin
    lg = '0;
    for (int i = 0; i < VBYTES_W; i++) begin
      if (vector_bytes_i[i]) begin
        lg = LG_W'(i);
      end
    end
  end

  always_comb begin
    dec_o          = '0;
    dec_o.is_store = store;
    dec_o.nf_m1    = instruction_i[31:29];
    dec_o.vd       = instruction_i[11:7];
    dec_o.lg       = lg;
    dec_o.size_lg  = indexed ? vector_type_i[4:3] : f3[1:0];
    dec_o.lmul_sh  = (!whole && !vector_type_i[2]) ? vector_type_i[1:0] : 2'd0;
    if (indexed) begin
      dec_o.mode = MODE_INDEXED;
    end else if (mop == MOP_STRIDE) begin
      dec_o.mode = MODE_STRIDED;
    end else if (whole) begin
      dec_o.mode = MODE_WHOLE;
    end else begin
      dec_o.mode = MODE_UNIT;
    end
    if (reject) begin
      dec_o.status = ST_REJECT;
    end else if (!instruction_i[25] && !mask_bit_i) begin
      dec_o.status = ST_MASKED;
    end else begin
      dec_o.status = ST_ACCESS;
    end
  end

endmodule

@@ rtl/core/vmag_field_seq.sv @@
`timescale 1ns / 1ps

module vmag_field_seq import vmag_pkg::*; #(
  parameter int unsigned OFF_W = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dec_t                dec_i,
  input  logic [63:0]         addr_i,
  input  logic [OFF_W-1:0]    off_i,
  input  logic [OFF_W-1:0]    grp_bytes_i,
  input  logic [VBYTES_W-1:0] step_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [63:0]         memory_address_o,
  output logic [4:0]          register_number_o,
  output logic [7:0]          register_offset_o,
  output logic [3:0]          access_bytes_o,
  output logic                is_store_o,
  output logic [2:0]          field_number_o,
  output logic                last_o
);

  logic                e_v_q;
  dec_t                dec_q;
  logic [2:0]          f_q;
  logic [63:0]         addr_q;
  logic [OFF_W-1:0]    off_q;
  logic [OFF_W-1:0]    lmul_q;
  logic [VBYTES_W-1:0] step_q;

  logic                out_v_q;
  status_e             status_q;
  logic [63:0]         maddr_q;
  logic [4:0]          reg_q;
  logic [7:0]          roff_q;
  logic [3:0]          bytes_q;
  logic                store_q;
  logic [2:0]          field_q;
  logic                last_q;

  logic                out_free;
  logic                emit;
  logic                e_last;
  logic                load;
  logic [OFF_W-1:0]    reg_sel;
  logic [OFF_W-1:0]    roff_mask;

  assign out_free   = !out_v_q || !out_stall_i;
  assign emit       = e_v_q && out_free;
  assign e_last     = (dec_q.status != ST_ACCESS) || (f_q == dec_q.nf_m1);
  assign in_ready_o = !e_v_q || (out_free && e_last);
  assign load       = in_valid_i && in_ready_o;

  // group byte offset -> register index and byte within it
  assign reg_sel   = off_q >> dec_q.lg;
  assign roff_mask = ~({OFF_W{1'b1}} << dec_q.lg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        e_v_q <= 1'b1;
      end else if (emit && e_last) begin
        e_v_q <= 1'b0;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dec_q  <= dec_i;
      f_q    <= 3'd0;
      addr_q <= addr_i;
      off_q  <= off_i;
      lmul_q <= grp_bytes_i;
      step_q <= step_i;
    end else if (emit && !e_last) begin
      f_q    <= f_q + 3'd1;
      addr_q <= addr_q + 64'(step_q);
      off_q  <= off_q + lmul_q;
    end
    if (emit) begin
      status_q <= dec_q.status;
      if (dec_q.status != ST_ACCESS) begin
        maddr_q <= '0;
        reg_q   <= '0;
        roff_q  <= '0;
        bytes_q <= '0;
        store_q <= 1'b0;
        field_q <= '0;
        last_q  <= 1'b1;
      end else begin
        maddr_q <= addr_q;
        reg_q   <= dec_q.vd + reg_sel[4:0];
        roff_q  <= 8'(off_q & roff_mask);
        bytes_q <= 4'd1 << dec_q.size_lg;
        store_q <= dec_q.is_store;
        field_q <= f_q;
        last_q  <= e_last;
      end
    end
  end

  assign out_valid_o       = out_v_q;
  assign status_o          = status_q;
  assign memory_address_o  = maddr_q;
  assign register_number_o = reg_q;
  assign register_offset_o = roff_q;
  assign access_bytes_o    = bytes_q;
  assign is_store_o        = store_q;
  assign field_number_o    = field_q;
  assign last_o            = last_q;

endmodule
